/* src/ssv_pkg.sv */
// ----------------------------------------------------------------------------
// ssv_pkg
// Shared types and constants of the session sequence validator: message
// kinds, error codes, table sizes and the item passed from front to back.
// ----------------------------------------------------------------------------
package ssv_pkg;

    localparam int NODE_COUNT       = 64;
    localparam int DEVICES_PER_NODE = 16;
    localparam int NODE_AW          = $clog2(NODE_COUNT);
    localparam int DEV_AW           = $clog2(DEVICES_PER_NODE);
    localparam int SEQ_W            = 8;
    localparam int BD_W             = 64;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW         = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 16;

    typedef enum logic [2:0] {
        MSG_NBIRTH = 3'd0,
        MSG_NDEATH = 3'd1,
        MSG_NDATA  = 3'd2,
        MSG_DBIRTH = 3'd3,
        MSG_DDATA  = 3'd4,
        MSG_DDEATH = 3'd5,
        MSG_OTHER  = 3'd6
    } msg_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_BIRTH_SEQ   = 3'd1,
        ERR_NO_BDSEQ    = 3'd2,
        ERR_NO_NBIRTH   = 3'd3,
        ERR_NO_DBIRTH   = 3'd4
    } err_code_t;

    typedef struct packed {
        msg_kind_t              kind;
        logic [NODE_AW-1:0]     node;
        logic [DEV_AW-1:0]      dev;
        logic                   has_seq;
        logic [SEQ_W-1:0]       seq;
        logic                   has_bd;
        logic [BD_W-1:0]        bd;
    } item_t;

endpackage

/* src/ssv_ram.sv */
// ----------------------------------------------------------------------------
// ssv_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module ssv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/ssv_front.sv */
// ----------------------------------------------------------------------------
// ssv_front
// Accepts messages, decodes the type and masks the bd_seq field when absent,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ssv_front
    import ssv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 q_valid,
    output item_t                q_item,
    input  logic                 q_pop
);

    item_t               queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    item_t               new_item;
    logic                push;

    always_comb begin
        unique case (s_tuser[2:0])
            MSG_NBIRTH: new_item.kind = MSG_NBIRTH;
            MSG_NDEATH: new_item.kind = MSG_NDEATH;
            MSG_NDATA:  new_item.kind = MSG_NDATA;
            MSG_DBIRTH: new_item.kind = MSG_DBIRTH;
            MSG_DDATA:  new_item.kind = MSG_DDATA;
            MSG_DDEATH: new_item.kind = MSG_DDEATH;
            default:    new_item.kind = MSG_OTHER;
        endcase
        new_item.node    = s_tdata[NODE_AW-1:0];
        new_item.dev     = s_tdata[6 +: DEV_AW];
        new_item.has_seq = s_tuser[3];
        new_item.seq     = s_tdata[17:10];
        new_item.has_bd  = s_tuser[4];
        new_item.bd      = s_tuser[4] ? s_tdata[81:18] : '0;
    end

    assign s_tready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

/* src/ssv_back.sv */
// ----------------------------------------------------------------------------
// ssv_back
// Reads the node and device state of the queued message, checks it,
// updates the state and registers the result for the output channel.
// ----------------------------------------------------------------------------
module ssv_back
    import ssv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 validate_enable,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [1:0] {
        ST_ISSUE = 2'b01,
        ST_EXEC  = 2'b10
    } state_t;

    state_t                      state_reg, state_next;
    item_t                       cur_reg;
    logic [NODE_COUNT-1:0]       node_born_reg;
    logic [NODE_COUNT-1:0]       row_valid_reg;
    logic                        m_tvalid_reg;
    logic [M_TDATA_W-1:0]        m_tdata_reg;

    logic [BD_W-1:0]             rd_bd;
    logic [SEQ_W-1:0]            rd_last;
    logic [DEVICES_PER_NODE-1:0] rd_row;
    logic [DEVICES_PER_NODE-1:0] dev_row;

    logic                        exec_fire;
    logic                        born;
    logic                        accepted;
    err_code_t                   err;
    logic                        gap;
    logic [SEQ_W-1:0]            expected;
    logic                        mismatch;
    logic                        bd_we;
    logic                        last_we;
    logic [SEQ_W-1:0]            last_wdata;
    logic                        row_we;
    logic [DEVICES_PER_NODE-1:0] row_wdata;
    logic                        set_born;

    assign q_pop     = (state_reg == ST_ISSUE) && q_valid;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    ssv_ram #(.WIDTH(BD_W), .DEPTH(NODE_COUNT)) u_bd_ram (
        .aclk  (aclk),
        .we    (bd_we),
        .waddr (cur_reg.node),
        .wdata (cur_reg.bd),
        .re    (q_pop),
        .raddr (q_item.node),
        .rdata (rd_bd)
    );

    ssv_ram #(.WIDTH(SEQ_W), .DEPTH(NODE_COUNT)) u_seq_ram (
        .aclk  (aclk),
        .we    (last_we),
        .waddr (cur_reg.node),
        .wdata (last_wdata),
        .re    (q_pop),
        .raddr (q_item.node),
        .rdata (rd_last)
    );

    ssv_ram #(.WIDTH(DEVICES_PER_NODE), .DEPTH(NODE_COUNT)) u_dev_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (cur_reg.node),
        .wdata (row_wdata),
        .re    (q_pop),
        .raddr (q_item.node),
        .rdata (rd_row)
    );

    assign born    = node_born_reg[cur_reg.node];
    assign dev_row = row_valid_reg[cur_reg.node] ? rd_row : '0;

    always_comb begin
        logic seq_check;
        seq_check  = 1'b0;
        accepted   = 1'b1;
        err        = ERR_NONE;
        gap        = 1'b0;
        expected   = '0;
        mismatch   = 1'b0;
        bd_we      = 1'b0;
        last_we    = 1'b0;
        last_wdata = '0;
        row_we     = 1'b0;
        row_wdata  = dev_row;
        set_born   = 1'b0;
        if (validate_enable) begin
            unique case (cur_reg.kind) inside
                MSG_NBIRTH: begin
                    if (cur_reg.has_seq && cur_reg.seq != '0) begin
                        accepted = 1'b0;
                        err      = ERR_BIRTH_SEQ;
                    end else if (!cur_reg.has_bd) begin
                        accepted = 1'b0;
                        err      = ERR_NO_BDSEQ;
                    end else begin
                        bd_we    = 1'b1;
                        last_we  = 1'b1;
                        set_born = 1'b1;
                    end
                end
                MSG_NDEATH: begin
                    mismatch = born && (cur_reg.bd != rd_bd);
                end
                MSG_NDATA, MSG_DBIRTH, MSG_DDATA: begin
                    if (!born) begin
                        accepted = 1'b0;
                        err      = ERR_NO_NBIRTH;
                    end else if (cur_reg.kind == MSG_DDATA && !dev_row[cur_reg.dev]) begin
                        accepted = 1'b0;
                        err      = ERR_NO_DBIRTH;
                    end else begin
                        seq_check = cur_reg.has_seq;
                        if (cur_reg.kind == MSG_DBIRTH) begin
                            row_we                 = 1'b1;
                            row_wdata[cur_reg.dev] = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (seq_check) begin
                expected   = rd_last + 1'b1;
                gap        = (cur_reg.seq != expected);
                last_we    = 1'b1;
                last_wdata = cur_reg.seq;
            end
        end
        bd_we   = bd_we && exec_fire;
        last_we = last_we && exec_fire;
        row_we  = row_we && exec_fire;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ISSUE: if (q_valid) state_next = ST_EXEC;
            ST_EXEC:  if (exec_fire) state_next = ST_ISSUE;
            default:  state_next = ST_ISSUE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ISSUE;
            node_born_reg <= '0;
            row_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec_fire && set_born) begin
                node_born_reg[cur_reg.node] <= 1'b1;
            end
            if (row_we) begin
                row_valid_reg[cur_reg.node] <= 1'b1;
            end
            if (exec_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_item;
        end
        if (exec_fire) begin
            m_tdata_reg <= {2'b00, mismatch, expected, gap, err, accepted};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* src/session_sequence_validator.sv */
// ----------------------------------------------------------------------------
// session_sequence_validator
// Host-side session checks per node and device: birth, death, data and
// sequence continuity, with accept/reject and error reporting per message.
// ----------------------------------------------------------------------------
//  port group   dir  fields (low bit first)
//  s_*          in   tdata: node_index, device_index, seq, bd_seq
//                    tuser: req_type, has_seq, has_bd
//  m_*          out  tdata: accepted, error_code, seq_gap, exp_seq,
//                    bdseq_mismatch
//  cfg_*        in   data: validate_enable
//
//  In the back end each message passes an issue state for the registered
//  state read, then an exec state to check, write back and load the output register.
//  The per-node state read-modify-write means no new message is taken until the last is through.
//  Reset clears all session state at once; no clearing pass follows.
//  A two-entry queue lets input be taken while the output is stalled, until it fills.
// ----------------------------------------------------------------------------
module session_sequence_validator
    import ssv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // node_index, device_index, seq, bd_seq
    input  logic [S_TUSER_W-1:0] s_tuser,  // req_type, has_seq, has_bd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // accepted, error_code, seq_gap,
                                           // exp_seq, bdseq_mismatch
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    logic  enable_reg;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
        end else if (cfg_valid) begin
            enable_reg <= cfg_data;
        end
    end

    ssv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ssv_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .validate_enable (enable_reg),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule
